/* rtl/assert_macros.svh */
// Assertion helpers for the checker file htlp_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTLP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTLP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/htlp_pkg.sv */
package htlp_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_W          = 31;
	localparam int STATUS_W       = 2;
	localparam int SLOT_W         = 4;
	localparam int PROBE_W        = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_FOUND     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

endpackage

/* rtl/htlp_ram.sv */
module htlp_ram #(
	parameter int DEPTH  = htlp_pkg::TABLE_SIZE_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = htlp_pkg::KEY_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/hash_table_linear_probe.sv */
// Linear-probing hash table, one probe per cycle through a single RAM read port.
// probe_count reports the probes made (1..TABLE_SIZE); a non power-of-two TABLE_SIZE first
// reduces the key modulo the size by reciprocal multiply: low half, high half, subtract.
// A new item is taken only once the current one has finished probing; the next
// beat may be taken while a result waits at the output register.
// Reset: a clearing pass writes every slot empty, with in_ready low.
module hash_table_linear_probe #(
	parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [htlp_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [htlp_pkg::STATUS_W-1:0] status,
	output logic [htlp_pkg::SLOT_W-1:0]   slot,
	output logic [htlp_pkg::PROBE_W-1:0]  probe_count
);

	import htlp_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
	localparam int HALF_W = 16;
	localparam int RCP_W  = KEY_W + 2;
	localparam int MUL_W  = RCP_W + HALF_W;
	localparam int ACC_W  = KEY_W + RCP_W;
	localparam int QSH    = KEY_W + IDX_W;
	localparam bit POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	localparam logic [IDX_W-1:0] LAST     = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);
	// (key * RECIP) >> QSH is the exact quotient for every key
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << QSH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [RCP_W-1:0]  RECIP   = RCP_W'(RECIP_WIDE);
	localparam logic [HALF_W-1:0] DIVISOR = HALF_W'(TABLE_SIZE);
	localparam logic [1:0] M_LO  = 2'd0;
	localparam logic [1:0] M_HI  = 2'd1;
	localparam logic [1:0] M_SUB = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_MOD   = 4'b0100,
		S_PROBE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        mstep_q;
	logic              out_valid_q;
	opcode_t           op_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  cur_q;
	logic [ACC_W-1:0]  acc_q;
	status_t           status_q;
	logic [IDX_W-1:0]  slot_q;
	logic [CNT_W-1:0]  probes_q;

	logic              accept;
	logic [ACC_W-1:0]  quo;
	logic [RCP_W-1:0]  mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [MUL_W-1:0]  mul_p;
	logic [IDX_W-1:0]  rem_idx;
	logic [KEY_W-1:0]  rd_data;
	logic              hit;
	logic [CNT_W-1:0]  cnt_inc;
	logic              last_probe;
	logic              out_free;
	logic              finish;
	logic [IDX_W-1:0]  cur_next;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [31:0]       slot_ext;
	logic [31:0]       probe_ext;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// one multiplier: key halves times the reciprocal, then quotient times the size
	assign quo = acc_q >> QSH;

	always_comb begin
		mul_a = RECIP;
		mul_b = key_q[HALF_W-1:0];
		unique case (mstep_q)
			M_HI: begin
				mul_b = HALF_W'(key_q[KEY_W-1:HALF_W]);
			end
			M_SUB: begin
				mul_a = quo[RCP_W-1:0];
				mul_b = DIVISOR;
			end
			default: begin
				mul_b = key_q[HALF_W-1:0];
			end
		endcase
	end

	assign mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
	// remainder is below TABLE_SIZE, so the low bits of key - q*size are enough
	assign rem_idx = key_q[IDX_W-1:0] - mul_p[IDX_W-1:0];

	assign hit        = (op_q == OP_SEARCH) ? (rd_data == key_q) : (rd_data == '0);
	assign cnt_inc    = cnt_q + 1'b1;
	assign last_probe = hit || (cnt_inc == FULL_CNT);
	assign out_free   = !out_valid_q || out_ready;
	assign finish     = (state_q == S_PROBE) && last_probe && out_free;
	assign cur_next   = (cur_q == LAST) ? '0 : cur_q + 1'b1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = cur_next;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				if (accept && POW2) begin
					ram_re    = 1'b1;
					ram_raddr = key[IDX_W-1:0];
				end
			end
			S_MOD: begin
				if (mstep_q == M_SUB) begin
					ram_re    = 1'b1;
					ram_raddr = rem_idx;
				end
			end
			S_PROBE: begin
				// next slot is fetched while the current one is compared
				ram_re = !last_probe;
				ram_we = finish && (op_q == OP_INSERT) && hit;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	htlp_ram #(
		.DEPTH  (TABLE_SIZE),
		.ADDR_W (IDX_W),
		.DATA_W (KEY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			mstep_q     <= M_LO;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						mstep_q <= M_LO;
						state_q <= POW2 ? S_PROBE : S_MOD;
					end
				end
				S_MOD: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == M_SUB) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (last_probe) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(opcode);
			key_q <= key;
			cur_q <= key[IDX_W-1:0];
		end
		if (state_q == S_MOD) begin
			if (mstep_q == M_LO) begin
				acc_q <= ACC_W'(mul_p);
			end else if (mstep_q == M_HI) begin
				acc_q <= acc_q + (ACC_W'(mul_p) << HALF_W);
			end
			if (mstep_q == M_SUB) begin
				cur_q <= rem_idx;
			end
		end
		if ((state_q == S_PROBE) && !last_probe) begin
			cur_q <= cur_next;
		end
		if (finish) begin
			if (op_q == OP_INSERT) begin
				status_q <= hit ? STAT_INSERTED : STAT_FULL;
			end else begin
				status_q <= hit ? STAT_FOUND : STAT_NOT_FOUND;
			end
			slot_q   <= hit ? cur_q : '0;
			probes_q <= cnt_inc;
		end
	end

	assign slot_ext  = 32'(slot_q);
	assign probe_ext = 32'(probes_q);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_ext[SLOT_W-1:0];
	assign probe_count = probe_ext[PROBE_W-1:0];

endmodule

/* rtl/htlp_chk.sv */
`include "assert_macros.svh"

module htlp_chk #(
	parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          opcode,
	input logic [htlp_pkg::KEY_W-1:0]    key,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [htlp_pkg::STATUS_W-1:0] status,
	input logic [htlp_pkg::SLOT_W-1:0]   slot,
	input logic [htlp_pkg::PROBE_W-1:0]  probe_count
);

	import htlp_pkg::*;

	localparam logic [PROBE_W-1:0] FULL_PROBES = PROBE_W'(TABLE_SIZE);

	logic fail_beat;

	assign fail_beat = out_valid && ((status == STAT_FULL) || (status == STAT_NOT_FOUND));

	`HTLP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(opcode) && $stable(key), "input beat dropped or changed while waiting")

	`HTLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot) && $stable(probe_count), "result beat dropped or changed while stalled")

	`HTLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "block took a second item without probing")

	`HTLP_ASSERT_NOW(a_fail_fields, fail_beat, (slot == '0) && (probe_count == FULL_PROBES), "failed lookup must report slot 0 and a full probe sweep")

	`HTLP_ASSERT_NOW(a_probe_nonzero, out_valid && (TABLE_SIZE < 32), probe_count != '0, "result with zero probes")

endmodule

bind hash_table_linear_probe htlp_chk #(
	.TABLE_SIZE (TABLE_SIZE)
) u_htlp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.opcode      (opcode),
	.key         (key),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.slot        (slot),
	.probe_count (probe_count)
);
